// ===== hw/rtl/bbc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and the character classifier for the bracket
// balance checker.
// ----------------------------------------------------------------------------
package bbc_pkg;

  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int POS_W       = 16;
  localparam int FIFO_DEPTH  = 4;
  localparam int FPTR_W      = $clog2(FIFO_DEPTH);
  localparam int FCNT_W      = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
  localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
  localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
  localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
  localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
  localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_EXTRA    = 3'd1,
    ST_MISMATCH = 3'd2,
    ST_UNCLOSED = 3'd3,
    ST_OVERFLOW = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    OP_NONE  = 2'd0,
    OP_OPEN  = 2'd1,
    OP_CLOSE = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    KIND_ROUND  = 2'd0,
    KIND_SQUARE = 2'd1,
    KIND_CURLY  = 2'd2
  } kind_t;

  typedef logic [POS_W-1:0] pos_t;

  // One classified character as handed from front to back.
  typedef struct packed {
    op_t   op;
    kind_t kind;
    pos_t  pos;
    logic  line_end;
  } cmd_t;

  typedef struct packed {
    kind_t kind;
    pos_t  pos;
  } entry_t;

  typedef struct packed {
    op_t   op;
    kind_t kind;
  } class_t;

  function automatic class_t classify(input logic [7:0] c);
    class_t r;
    r.op   = OP_NONE;
    r.kind = KIND_ROUND;
    unique case (c)
      CH_OPEN_ROUND:   begin r.op = OP_OPEN;  r.kind = KIND_ROUND;  end
      CH_OPEN_SQUARE:  begin r.op = OP_OPEN;  r.kind = KIND_SQUARE; end
      CH_OPEN_CURLY:   begin r.op = OP_OPEN;  r.kind = KIND_CURLY;  end
      CH_CLOSE_ROUND:  begin r.op = OP_CLOSE; r.kind = KIND_ROUND;  end
      CH_CLOSE_SQUARE: begin r.op = OP_CLOSE; r.kind = KIND_SQUARE; end
      CH_CLOSE_CURLY:  begin r.op = OP_CLOSE; r.kind = KIND_CURLY;  end
      default:         begin r.op = OP_NONE;  r.kind = KIND_ROUND;  end
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/bbc_in_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_in_if
// Character channel: one byte of the line per transfer.
// ----------------------------------------------------------------------------
interface bbc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       has_char;
  logic       line_end;

  modport source (output valid, output char_code, output has_char, output line_end,
                  input ready);
  modport sink   (input valid, input char_code, input has_char, input line_end,
                  output ready);
endinterface

// ===== hw/rtl/bbc_out_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_out_if
// Result channel: one status and position per line.
// ----------------------------------------------------------------------------
interface bbc_out_if;
  logic                     valid;
  logic                     ready;
  logic [2:0]               status;
  logic [bbc_pkg::POS_W-1:0] position;

  modport source (output valid, output status, output position, input ready);
  modport sink   (input valid, input status, input position, output ready);
endinterface

// ===== hw/rtl/bbc_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_front
// Accepts characters, tracks the saturating line position and classifies
// each byte into an open/close/none command for the back end.
// ----------------------------------------------------------------------------
module bbc_front (
  input  logic              clk,
  input  logic              rst,
  bbc_in_if.sink            char_in,
  output logic              cmd_valid,
  input  logic              cmd_ready,
  output bbc_pkg::cmd_t     cmd
);

  bbc_pkg::pos_t   pos;
  bbc_pkg::pos_t   pos_next;
  bbc_pkg::class_t cls;
  logic            take;

  assign char_in.ready = cmd_ready;
  assign cmd_valid     = char_in.valid;
  assign take          = char_in.valid && cmd_ready;

  always_comb begin
    cls      = bbc_pkg::classify(char_in.char_code);
    pos_next = pos;
    if (char_in.has_char && (pos != {bbc_pkg::POS_W{1'b1}})) begin
      pos_next = pos + bbc_pkg::POS_W'(1);
    end
    cmd.op       = char_in.has_char ? cls.op : bbc_pkg::OP_NONE;
    cmd.kind     = cls.kind;
    cmd.pos      = pos_next;
    cmd.line_end = char_in.line_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
    end else if (take) begin
      pos <= char_in.line_end ? '0 : pos_next;
    end
  end

endmodule

// ===== hw/rtl/bbc_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_fifo
// Short command queue between the front and the back end.
// ----------------------------------------------------------------------------
module bbc_fifo (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_valid,
  output logic          wr_ready,
  input  bbc_pkg::cmd_t wr_data,
  output logic          rd_valid,
  input  logic          rd_ready,
  output bbc_pkg::cmd_t rd_data
);

  bbc_pkg::cmd_t                  mem [bbc_pkg::FIFO_DEPTH];
  logic [bbc_pkg::FPTR_W-1:0]     wptr;
  logic [bbc_pkg::FPTR_W-1:0]     rptr;
  logic [bbc_pkg::FCNT_W-1:0]     count;
  logic                           push;
  logic                           pop;

  assign wr_ready = (count != bbc_pkg::FCNT_W'(bbc_pkg::FIFO_DEPTH));
  assign rd_valid = (count != '0);
  assign rd_data  = mem[rptr];
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= wptr + bbc_pkg::FPTR_W'(1);
      if (pop)  rptr <= rptr + bbc_pkg::FPTR_W'(1);
      unique case ({push, pop})
        2'b10:   count <= count + bbc_pkg::FCNT_W'(1);
        2'b01:   count <= count - bbc_pkg::FCNT_W'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

// ===== hw/rtl/bbc_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bbc_back
// Executes bracket commands against the stack: the top entry lives in a
// register, the entry below it is kept as the registered memory read data.
// Latches the first error and forms the line result.
// ----------------------------------------------------------------------------
module bbc_back (
  input  logic          clk,
  input  logic          rst,
  input  logic          cmd_valid,
  output logic          cmd_ready,
  input  bbc_pkg::cmd_t cmd,
  bbc_out_if.source     result_out
);

  bbc_pkg::entry_t                 stack_mem [bbc_pkg::STACK_DEPTH];
  bbc_pkg::entry_t                 top;
  bbc_pkg::entry_t                 top_next;
  bbc_pkg::entry_t                 below;      // registered read: entry count-2
  logic [bbc_pkg::CNT_W-1:0]       count;
  logic [bbc_pkg::CNT_W-1:0]       count_next;
  logic [bbc_pkg::CNT_W-1:0]       count_m1;
  logic [bbc_pkg::CNT_W-1:0]       rd_cnt;
  bbc_pkg::status_t                err;
  bbc_pkg::status_t                err_next;
  bbc_pkg::pos_t                   err_pos;
  bbc_pkg::pos_t                   err_pos_next;
  logic                            we;
  logic [bbc_pkg::ADDR_W-1:0]      waddr;
  logic [bbc_pkg::ADDR_W-1:0]      raddr;
  logic                            take;
  bbc_pkg::status_t                res_status;
  bbc_pkg::pos_t                   res_pos;

  logic                            out_valid;
  bbc_pkg::status_t                out_status;
  bbc_pkg::pos_t                   out_position;

  assign cmd_ready = !out_valid || result_out.ready;
  assign take      = cmd_valid && cmd_ready;
  assign count_m1  = count - bbc_pkg::CNT_W'(1);
  assign waddr     = count_m1[bbc_pkg::ADDR_W-1:0];

  always_comb begin
    top_next     = top;
    count_next   = count;
    err_next     = err;
    err_pos_next = err_pos;
    we           = 1'b0;
    if (take && (err == bbc_pkg::ST_OK)) begin
      unique case (cmd.op)
        bbc_pkg::OP_OPEN: begin
          if (count == bbc_pkg::CNT_W'(bbc_pkg::STACK_DEPTH)) begin
            err_next     = bbc_pkg::ST_OVERFLOW;
            err_pos_next = cmd.pos;
          end else begin
            // old top moves down into the memory
            we             = (count != '0);
            top_next.kind  = cmd.kind;
            top_next.pos   = cmd.pos;
            count_next     = count + bbc_pkg::CNT_W'(1);
          end
        end
        bbc_pkg::OP_CLOSE: begin
          if (count == '0) begin
            err_next     = bbc_pkg::ST_EXTRA;
            err_pos_next = cmd.pos;
          end else if (top.kind != cmd.kind) begin
            err_next     = bbc_pkg::ST_MISMATCH;
            err_pos_next = cmd.pos;
          end else begin
            top_next   = below;
            count_next = count_m1;
          end
        end
        default: begin
        end
      endcase
    end

    if (err_next != bbc_pkg::ST_OK) begin
      res_status = err_next;
      res_pos    = err_pos_next;
    end else if (count_next != '0) begin
      res_status = bbc_pkg::ST_UNCLOSED;
      res_pos    = top_next.pos;
    end else begin
      res_status = bbc_pkg::ST_OK;
      res_pos    = '0;
    end

    rd_cnt = count_next - bbc_pkg::CNT_W'(2);
    raddr  = rd_cnt[bbc_pkg::ADDR_W-1:0];
  end

  // Stack memory; the read port prefetches the entry below the next top.
  always_ff @(posedge clk) begin
    if (we) begin
      stack_mem[waddr] <= top;
    end
    if (we && (waddr == raddr)) begin
      below <= top;
    end else begin
      below <= stack_mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    top <= top_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      err     <= bbc_pkg::ST_OK;
      err_pos <= '0;
    end else if (take && cmd.line_end) begin
      count   <= '0;
      err     <= bbc_pkg::ST_OK;
      err_pos <= '0;
    end else begin
      count   <= count_next;
      err     <= err_next;
      err_pos <= err_pos_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take && cmd.line_end) begin
      out_valid <= 1'b1;
    end else if (result_out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take && cmd.line_end) begin
      out_status   <= res_status;
      out_position <= res_pos;
    end
  end

  assign result_out.valid    = out_valid;
  assign result_out.status   = out_status;
  assign result_out.position = out_position;

endmodule

// ===== hw/rtl/bracket_balance_checker_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bracket_balance_checker_top
// Checks round, square and curly bracket nesting of a text line.
// ----------------------------------------------------------------------------
// Usage:
//   char_in takes one character byte per transfer (valid/ready). has_char = 0
//   marks an empty item; line_end = 1 closes the line.
//   result_out gives exactly one transfer per line: status (ok, extra closing,
//   mismatch, unclosed, stack overflow) and the 1-based position of the
//   offending character or innermost open bracket (0 when ok).
//   Throughput is one character per cycle unless a stalled result_out holds
//   the back end: the front end classifies and counts positions, a 4-entry
//   command queue feeds the back end, which keeps the top of the 128-entry
//   stack in a register and the entry below it as the prefetched memory read.
//   result_out.valid is registered: the line_end command passes through the
//   queue, then the result register.
//   While a result waits on a stalled result_out, the back end holds; the
//   queue takes up to four more transfers, then char_in.ready drops.
//   Synchronous reset (rst) clears positions, stack count, the error latch,
//   the queue and the result register; stack contents need no clearing.
// ----------------------------------------------------------------------------
module bracket_balance_checker_top (
  input  logic      clk,
  input  logic      rst,
  bbc_in_if.sink    char_in,
  bbc_out_if.source result_out
);

  logic          f_valid;
  logic          f_ready;
  bbc_pkg::cmd_t f_cmd;
  logic          b_valid;
  logic          b_ready;
  bbc_pkg::cmd_t b_cmd;

  bbc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .cmd_valid (f_valid),
    .cmd_ready (f_ready),
    .cmd       (f_cmd)
  );

  bbc_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (f_valid),
    .wr_ready (f_ready),
    .wr_data  (f_cmd),
    .rd_valid (b_valid),
    .rd_ready (b_ready),
    .rd_data  (b_cmd)
  );

  bbc_back u_back (
    .clk        (clk),
    .rst        (rst),
    .cmd_valid  (b_valid),
    .cmd_ready  (b_ready),
    .cmd        (b_cmd),
    .result_out (result_out)
  );

endmodule

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for bracket_balance_checker_top. A short table of
// directed lines comes first. A deep line then drives the stack to full and
// into overflow. Random lines follow, mostly well nested with some broken
// ones. Each line result is compared against a behavioral bracket-stack
// model of the line. Both channels get random stalls in some phases and
// none in others.
// ----------------------------------------------------------------------------
module tb_top;

  // The limit leaves a wide margin over the time that about 400 items take,
  // even under heavy stalls.
  localparam int LIMIT_CYCLES          = 50_000;
  localparam int DRAIN_CYCLES          = 20;
  localparam int RAND_ITEMS_PER_PHASE  = 70;
  localparam bbc_pkg::pos_t POS_MAX    = '1;

  localparam logic [7:0] OPEN_CHARS  [3] = '{bbc_pkg::CH_OPEN_ROUND,
                                             bbc_pkg::CH_OPEN_SQUARE,
                                             bbc_pkg::CH_OPEN_CURLY};
  localparam logic [7:0] CLOSE_CHARS [3] = '{bbc_pkg::CH_CLOSE_ROUND,
                                             bbc_pkg::CH_CLOSE_SQUARE,
                                             bbc_pkg::CH_CLOSE_CURLY};

  typedef struct packed {
    logic [7:0] char_code;
    logic       has_char;
    logic       line_end;
  } char_item_t;

  typedef struct packed {
    bbc_pkg::status_t status;
    bbc_pkg::pos_t    position;
  } line_result_t;

  typedef struct packed {
    char_item_t   item;
    logic         typed;
    line_result_t res;
  } dir_row_t;

  localparam line_result_t NO_RES = '{bbc_pkg::ST_OK, 16'd0};

  // Directed lines; a typed result is used where the answer is obvious.
  dir_row_t dir_rows [25] = '{
    '{'{8'h00,                    1'b0, 1'b1}, 1'b1, '{bbc_pkg::ST_OK,       16'd0}},
    '{'{bbc_pkg::CH_CLOSE_ROUND,  1'b1, 1'b1}, 1'b1, '{bbc_pkg::ST_EXTRA,    16'd1}},
    '{'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b1}, 1'b1, '{bbc_pkg::ST_MISMATCH, 16'd2}},
    '{'{bbc_pkg::CH_OPEN_CURLY,   1'b1, 1'b1}, 1'b1, '{bbc_pkg::ST_UNCLOSED, 16'd1}},
    '{'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{8'hFF,                    1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{8'h00,                    1'b0, 1'b1}, 1'b1, '{bbc_pkg::ST_OK,       16'd0}},
    '{'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_OPEN_CURLY,   1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{8'h7D,                    1'b0, 1'b0}, 1'b0, NO_RES},  // no char, ignored
    '{'{bbc_pkg::CH_CLOSE_CURLY,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_ROUND,  1'b1, 1'b1}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_CURLY,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0}, 1'b0, NO_RES},  // after error
    '{'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b1}, 1'b1, '{bbc_pkg::ST_EXTRA,    16'd1}},
    '{'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_CURLY,  1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_CLOSE_SQUARE, 1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{8'h55,                    1'b1, 1'b1}, 1'b1, '{bbc_pkg::ST_MISMATCH, 16'd2}},
    '{'{bbc_pkg::CH_OPEN_ROUND,   1'b1, 1'b0}, 1'b0, NO_RES},
    '{'{bbc_pkg::CH_OPEN_SQUARE,  1'b1, 1'b1}, 1'b0, NO_RES}
  };

  logic clk = 1'b0;
  logic rst;

  bbc_in_if  char_in();
  bbc_out_if result_out();

  bracket_balance_checker_top dut (
    .clk       (clk),
    .rst       (rst),
    .char_in   (char_in),
    .result_out(result_out)
  );

  always #5 clk = ~clk;

  // line model state
  bbc_pkg::entry_t  open_stack [bbc_pkg::STACK_DEPTH];
  int unsigned      open_count     = 0;
  bbc_pkg::pos_t    line_pos       = '0;
  bbc_pkg::status_t latched_status = bbc_pkg::ST_OK;
  bbc_pkg::pos_t    latched_pos    = '0;

  line_result_t expected_results [$];

  int unsigned src_idle_pct  = 0;
  int unsigned snk_idle_pct  = 0;
  int unsigned cycles        = 0;
  int unsigned errors        = 0;
  int unsigned lines_checked = 0;
  int unsigned chars_sent    = 0;
  int unsigned rand_items    = 0;

  // Advances the line model by one character; returns 1 with the line
  // result when the item closes the line.
  function automatic bit check_char(input char_item_t it, output line_result_t res);
    logic           is_open;
    logic           is_close;
    bbc_pkg::kind_t k;
    res      = NO_RES;
    is_open  = 1'b0;
    is_close = 1'b0;
    k        = bbc_pkg::KIND_ROUND;
    if (it.has_char) begin
      if (line_pos != POS_MAX) line_pos++;
      case (it.char_code)
        bbc_pkg::CH_OPEN_ROUND:   begin is_open  = 1'b1; k = bbc_pkg::KIND_ROUND;  end
        bbc_pkg::CH_OPEN_SQUARE:  begin is_open  = 1'b1; k = bbc_pkg::KIND_SQUARE; end
        bbc_pkg::CH_OPEN_CURLY:   begin is_open  = 1'b1; k = bbc_pkg::KIND_CURLY;  end
        bbc_pkg::CH_CLOSE_ROUND:  begin is_close = 1'b1; k = bbc_pkg::KIND_ROUND;  end
        bbc_pkg::CH_CLOSE_SQUARE: begin is_close = 1'b1; k = bbc_pkg::KIND_SQUARE; end
        bbc_pkg::CH_CLOSE_CURLY:  begin is_close = 1'b1; k = bbc_pkg::KIND_CURLY;  end
        default: ;
      endcase
      if (latched_status == bbc_pkg::ST_OK) begin
        if (is_open) begin
          if (open_count == bbc_pkg::STACK_DEPTH) begin
            latched_status = bbc_pkg::ST_OVERFLOW;
            latched_pos    = line_pos;
          end else begin
            open_stack[open_count] = '{kind: k, pos: line_pos};
            open_count++;
          end
        end else if (is_close) begin
          if (open_count == 0) begin
            latched_status = bbc_pkg::ST_EXTRA;
            latched_pos    = line_pos;
          end else if (open_stack[open_count-1].kind != k) begin
            latched_status = bbc_pkg::ST_MISMATCH;
            latched_pos    = line_pos;
          end else begin
            open_count--;
          end
        end
      end
    end
    if (!it.line_end) return 1'b0;
    if (latched_status != bbc_pkg::ST_OK) res = '{latched_status, latched_pos};
    else if (open_count != 0) res = '{bbc_pkg::ST_UNCLOSED, open_stack[open_count-1].pos};
    else                      res = NO_RES;
    open_count     = 0;
    line_pos       = '0;
    latched_status = bbc_pkg::ST_OK;
    latched_pos    = '0;
    return 1'b1;
  endfunction

  function automatic logic [7:0] plain_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(255));
    while (b inside {bbc_pkg::CH_OPEN_ROUND, bbc_pkg::CH_OPEN_SQUARE,
                     bbc_pkg::CH_OPEN_CURLY, bbc_pkg::CH_CLOSE_ROUND,
                     bbc_pkg::CH_CLOSE_SQUARE, bbc_pkg::CH_CLOSE_CURLY});
    return b;
  endfunction

  // Mostly nested lines with random filler; about a third carry stray
  // closers, raw bytes and unclosed openers.
  function automatic void build_line(ref char_item_t line [$]);
    int unsigned len;
    int unsigned r;
    int          k;
    bit          noisy;
    int          kinds [$];
    char_item_t  it;
    line.delete();
    noisy = ($urandom_range(99) < 35);
    len   = $urandom_range(1, 24);
    for (int i = 0; i < len; i++) begin
      r           = $urandom_range(99);
      it.has_char = 1'b1;
      it.line_end = 1'b0;
      if (r < 40) begin
        k = $urandom_range(2);
        kinds.push_back(k);
        it.char_code = OPEN_CHARS[k];
      end else if (r < 75 && kinds.size() > 0) begin
        it.char_code = CLOSE_CHARS[kinds.pop_back()];
      end else if (r < 90) begin
        it.char_code = noisy ? 8'($urandom_range(255)) : plain_byte();
      end else if (r < 95 || !noisy) begin
        it.has_char  = 1'b0;
        it.char_code = 8'($urandom_range(255));
      end else begin
        it.char_code = CLOSE_CHARS[$urandom_range(2)];
      end
      line.push_back(it);
    end
    if (!noisy || $urandom_range(1)) begin
      while (kinds.size() > 0) begin
        it.has_char  = 1'b1;
        it.line_end  = 1'b0;
        it.char_code = CLOSE_CHARS[kinds.pop_back()];
        line.push_back(it);
      end
    end
    if ($urandom_range(1)) begin
      line[line.size()-1].line_end = 1'b1;
    end else begin
      it.has_char  = 1'b0;
      it.line_end  = 1'b1;
      it.char_code = 8'($urandom_range(255));
      line.push_back(it);
    end
  endfunction

  task automatic send_char(input char_item_t it, input logic typed,
                           input line_result_t typed_res);
    logic         got;
    line_result_t res;
    while ($urandom_range(99) < src_idle_pct) begin
      char_in.valid <= 1'b0;
      @(posedge clk);
    end
    char_in.valid     <= 1'b1;
    char_in.char_code <= it.char_code;
    char_in.has_char  <= it.has_char;
    char_in.line_end  <= it.line_end;
    // ready is stable mid-cycle, so the negedge value decides the transfer
    do begin
      @(negedge clk);
      got = char_in.ready;
      @(posedge clk);
    end while (!got);
    if (it.has_char) chars_sent++;
    if (check_char(it, res)) expected_results.push_back(typed ? typed_res : res);
  endtask

  task automatic send_line(ref char_item_t line [$]);
    foreach (line[i]) send_char(line[i], 1'b0, NO_RES);
  endtask

  // openers > STACK_DEPTH runs into overflow; without closing it is unclosed
  task automatic send_deep_line(input int openers, input bit close_all);
    char_item_t line [$];
    int         kinds [$];
    int         k;
    for (int i = 0; i < openers; i++) begin
      k = $urandom_range(2);
      kinds.push_back(k);
      line.push_back('{OPEN_CHARS[k], 1'b1, 1'b0});
      if ($urandom_range(3) == 0) line.push_back('{plain_byte(), 1'b1, 1'b0});
    end
    if (close_all) begin
      while (kinds.size() > 0) line.push_back('{CLOSE_CHARS[kinds.pop_back()], 1'b1, 1'b0});
    end
    line.push_back('{plain_byte(), 1'b1, 1'b1});
    send_line(line);
  endtask

  always @(posedge clk) begin
    result_out.ready <= ($urandom_range(99) >= snk_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("simulation failed");
      $finish;
    end
  end

  // result transfer checked mid-cycle, before the edge that completes it
  always @(negedge clk) begin
    line_result_t exp_res;
    if (!rst && result_out.valid && result_out.ready) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result, status %0d position %0d",
                 $time, result_out.status, result_out.position);
        errors++;
      end else begin
        exp_res = expected_results.pop_front();
        lines_checked++;
        if (result_out.status !== exp_res.status ||
            result_out.position !== exp_res.position) begin
          $display("%0t: mismatch, expected status %0d position %0d, got status %0d position %0d",
                   $time, exp_res.status, exp_res.position,
                   result_out.status, result_out.position);
          errors++;
        end
      end
    end
  end

  initial begin
    char_item_t line [$];
    int unsigned target;
    rst                <= 1'b1;
    char_in.valid      <= 1'b0;
    char_in.char_code  <= 8'h00;
    char_in.has_char   <= 1'b0;
    char_in.line_end   <= 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    for (int p = 0; p < 3; p++) begin
      src_idle_pct = (p == 0) ? 20 : (p == 1) ? 53 : 0;
      snk_idle_pct = (p == 0) ? 53 : (p == 1) ? 20 : 0;
      if (p == 0) begin
        foreach (dir_rows[i]) send_char(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
        // fills the stack, then one more opener overflows it
        send_deep_line(bbc_pkg::STACK_DEPTH + 1, 1'b0);
      end
      target = rand_items + RAND_ITEMS_PER_PHASE;
      while (rand_items < target) begin
        build_line(line);
        foreach (line[i]) if (line[i].has_char || line[i].line_end) rand_items++;
        send_line(line);
      end
    end
    char_in.valid <= 1'b0;

    while (expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d line results over %0d characters, under sender and receiver stalls.",
             lines_checked, chars_sent);
    $display("Covered every status code, a full stack and its overflow, and empty items.");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
